// File: sv/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, controller states and command/status types of the byte
// entropy block.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

    localparam int MAX_LEN_BITS = 20;
    localparam int CNT_W        = MAX_LEN_BITS + 1;
    localparam int NUM_BINS     = 256;
    localparam int BIN_W        = 8;
    localparam int FRAC_BITS    = 16;
    localparam int EXP_W        = 5;
    localparam int LOG_W        = EXP_W + FRAC_BITS;
    localparam int SUM_W        = CNT_W + LOG_W;
    localparam int M_W          = 32;
    localparam int M_FRAC       = 30;
    localparam int ENT_W        = 20;
    localparam int ITER_W       = 5;
    localparam int DIV_CNT_W    = 6;

    localparam logic [CNT_W-1:0] MAX_LEN     = CNT_W'(1) << MAX_LEN_BITS;
    localparam logic [LOG_W-1:0] ENTROPY_MAX = LOG_W'(8) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_BIN_RD,
        S_BIN_CHK,
        S_LOG,
        S_MAC,
        S_NLOG_ST,
        S_NLOG,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic byte_rd;
        logic byte_wr;
        logic bin_start;
        logic bin_rd;
        logic bin_next;
        logic log_f;
        logic log_n;
        logic mac;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic bin_zero;
        logic bin_last;
        logic log_busy;
        logic div_busy;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

// File: sv/bse_log2.sv
// ----------------------------------------------------------------------------
// bse_log2
// Iterative fixed-point log2: leading-one exponent, then one mantissa squaring
// per cycle for sixteen fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_log2 (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [bse_pkg::CNT_W-1:0] x,
    output logic                         busy,
    output logic [bse_pkg::LOG_W-1:0]    result
);
    import bse_pkg::*;

    logic [M_W-1:0]    m_reg, m_next;
    logic [LOG_W-1:0]  r_reg, r_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [EXP_W-1:0]  e;
    logic [2*M_W-1:0]  sq;
    logic [M_W-1:0]    mm;

    always_comb
    begin
        e = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (x[i])
            begin
                e = EXP_W'(i);
            end
        end
    end

    assign sq = m_reg * m_reg;
    assign mm = sq[M_W+M_FRAC-1:M_FRAC];

    always_comb
    begin
        m_next   = m_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            m_next   = M_W'(x) << (EXP_W'(M_FRAC) - e);
            r_next   = LOG_W'(e) << FRAC_BITS;
            cnt_next = ITER_W'(FRAC_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            // mantissa reached 2.0: emit a one and renormalize
            if (mm[M_W-1])
            begin
                m_next = mm >> 1;
                r_next = r_reg | (LOG_W'(1) << (cnt_reg - 1'b1));
            end
            else
            begin
                m_next = mm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign busy   = (cnt_reg != '0);
    assign result = r_reg;

endmodule

`default_nettype wire

// File: sv/bse_div.sv
// ----------------------------------------------------------------------------
// bse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bse_pkg::SUM_W-1:0] dividend,
    input  wire logic [bse_pkg::CNT_W-1:0] divisor,
    output logic                           busy,
    output logic [bse_pkg::SUM_W-1:0]      quotient
);
    import bse_pkg::*;

    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W:0]       trial;
    logic                 take;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign take  = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(SUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], take};
            rem_reg <= take ? CNT_W'(trial - {1'b0, d_reg}) : trial[CNT_W-1:0];
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: sv/bse_datapath.sv
// ----------------------------------------------------------------------------
// bse_datapath
// Histogram memory with valid bits, byte counter, log/multiply-accumulate,
// divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bse_pkg::cmd_t              cmd,
    output bse_pkg::status_t                status,
    input  wire logic [bse_pkg::BIN_W-1:0]  in_byte,
    input  wire logic                       in_last,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [bse_pkg::ENT_W-1:0]       out_entropy,
    output logic [bse_pkg::CNT_W-1:0]       out_count,
    output logic                            out_overflow
);
    import bse_pkg::*;

    logic [CNT_W-1:0]    mem [NUM_BINS];
    logic [CNT_W-1:0]    rdata_reg;
    logic                valid_rd_reg;
    logic [NUM_BINS-1:0] valid_reg;
    logic [BIN_W-1:0]    byte_reg;
    logic                last_reg;
    logic [BIN_W-1:0]    bin_idx_reg;
    logic [CNT_W-1:0]    total_reg;
    logic                sat_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [LOG_W-1:0]    ln_reg;
    logic                out_valid_reg;
    logic [ENT_W-1:0]    ent_reg;
    logic [CNT_W-1:0]    cnt_out_reg;
    logic                ovf_reg;

    logic [BIN_W-1:0]    addr;
    logic [CNT_W-1:0]    f;
    logic                we;
    logic                log_busy;
    logic [LOG_W-1:0]    log_res;
    logic                div_busy;
    logic [SUM_W-1:0]    quo;
    logic [LOG_W-1:0]    ent;
    logic [LOG_W-1:0]    diff;

    assign addr = cmd.bin_rd ? bin_idx_reg : byte_reg;
    assign f    = valid_rd_reg ? rdata_reg : '0;
    assign we   = cmd.byte_wr && (total_reg != MAX_LEN);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[byte_reg] <= f + 1'b1;
        end
        // hold the read word until the next byte or bin read
        if (cmd.byte_rd || cmd.bin_rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    bse_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_f || cmd.log_n),
        .x      (cmd.log_n ? total_reg : f),
        .busy   (log_busy),
        .result (log_res)
    );

    bse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (total_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign diff = ln_reg - quo[LOG_W-1:0];

    always_comb
    begin
        if (quo >= SUM_W'(ln_reg))
        begin
            ent = '0;
        end
        else if (diff > ENTROPY_MAX)
        begin
            ent = ENTROPY_MAX;
        end
        else
        begin
            ent = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            valid_rd_reg  <= 1'b0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            sum_reg       <= '0;
            bin_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.byte_rd || cmd.bin_rd)
            begin
                valid_rd_reg <= valid_reg[addr];
            end
            if (cmd.byte_wr)
            begin
                if (total_reg == MAX_LEN)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    valid_reg[byte_reg] <= 1'b1;
                    total_reg           <= total_reg + 1'b1;
                end
            end
            if (cmd.bin_start)
            begin
                bin_idx_reg <= '0;
            end
            else if (cmd.bin_next)
            begin
                bin_idx_reg <= bin_idx_reg + 1'b1;
            end
            // clear each bin as it is read out
            if (cmd.bin_rd)
            begin
                valid_reg[bin_idx_reg] <= 1'b0;
            end
            if (cmd.mac)
            begin
                sum_reg <= sum_reg + SUM_W'(f * log_res);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= '0;
                sat_reg       <= 1'b0;
                sum_reg       <= '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.div_start)
        begin
            ln_reg <= log_res;
        end
        if (cmd.load_out)
        begin
            ent_reg     <= ent[ENT_W-1:0];
            cnt_out_reg <= total_reg;
            ovf_reg     <= sat_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.bin_zero = (f == '0);
    assign status.bin_last = (bin_idx_reg == BIN_W'(NUM_BINS - 1));
    assign status.log_busy = log_busy;
    assign status.div_busy = div_busy;
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_entropy  = ent_reg;
    assign out_count    = cnt_out_reg;
    assign out_overflow = ovf_reg;

endmodule

`default_nettype wire

// File: sv/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: byte read-modify-write, bin sweep, log of the count, divide and
// result load.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output bse_pkg::cmd_t         cmd,
    input  wire bse_pkg::status_t status
);
    import bse_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.byte_wr = 1'b1;
                if (status.last)
                begin
                    cmd.bin_start = 1'b1;
                    state_next    = S_BIN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BIN_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = S_BIN_CHK;
            end
            S_BIN_CHK:
            begin
                if (!status.bin_zero)
                begin
                    cmd.log_f  = 1'b1;
                    state_next = S_LOG;
                end
                else if (status.bin_last)
                begin
                    state_next = S_NLOG_ST;
                end
                else
                begin
                    cmd.bin_next = 1'b1;
                    state_next   = S_BIN_RD;
                end
            end
            S_LOG:
            begin
                if (!status.log_busy)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac = 1'b1;
                if (status.bin_last)
                begin
                    state_next = S_NLOG_ST;
                end
                else
                begin
                    cmd.bin_next = 1'b1;
                    state_next   = S_BIN_RD;
                end
            end
            S_NLOG_ST:
            begin
                cmd.log_n  = 1'b1;
                state_next = S_NLOG;
            end
            S_NLOG:
            begin
                if (!status.log_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the previous result has been taken
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/byte_shannon_entropy.sv
// ----------------------------------------------------------------------------
// byte_shannon_entropy
// Byte histogram and Shannon entropy in bits per byte, Q.16, per block.
// ----------------------------------------------------------------------------
// Flow: a byte beat passes capture, read and write (histogram read-modify-write
// port). End of block: every bin is read and checked, a nonzero bin adding log2
// and multiply-accumulate; then log2 of the count, divide and result load.
// New bytes are taken while a result waits; the next result load holds until
// it is taken. Reset: asynchronous, active low; clears the histogram valid
// bits, count, overflow flag and output valid at once, no clearing pass.
`default_nettype none

module byte_shannon_entropy (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [19:0] entropy, [40:20] byte_count
    output logic             m_tuser    // [0] overflow
);
    import bse_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [ENT_W-1:0] entropy;
    logic [CNT_W-1:0] byte_count;

    bse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bse_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_byte      (s_tdata[BIN_W-1:0]),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_entropy  (entropy),
        .out_count    (byte_count),
        .out_overflow (m_tuser)
    );

    assign m_tdata = {7'b0, byte_count, entropy};

endmodule

`default_nettype wire

// File: sv/bse_checker.sv
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks of the byte entropy block.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("byte taken before previous update finished");

    a_ent_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:0] <= 20'd524288)
        else $error("entropy above 8 bits per byte");

    a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[40:20] != 21'd0)
        else $error("result with empty block");

    a_ovf_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[40:20] == 21'd1048576)
        else $error("overflow without saturated count");

endmodule

bind byte_shannon_entropy bse_checker u_bse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
